/* rtl/bech32chk_pkg.sv */
// shared types, constants and functions of the bech32 segwit v0 address checker
package bech32chk_pkg;

   localparam int unsigned MAX_CHARS     = 90;
   localparam int unsigned PROGRAM_BYTES = 20;
   localparam int unsigned MIN_CHARS     = 14;
   localparam int unsigned POS_SAT       = 127;
   localparam int unsigned BYTES_SAT     = 63;
   localparam int unsigned DELAY_DEPTH   = 6;
   localparam int unsigned QUEUE_AW      = 2;
   localparam int unsigned QUEUE_DEPTH   = 1 << QUEUE_AW;

   localparam logic [7:0] CH_B   = 8'h62;
   localparam logic [7:0] CH_C   = 8'h63;
   localparam logic [7:0] CH_ONE = 8'h31;

   // classified character as it travels from the front to the back
   typedef struct packed {
      logic       bad_char;
      logic       is_b;
      logic       is_c;
      logic       is_one;
      logic       in_set;
      logic [4:0] value;
      logic       last;
   } class_type;

   function automatic logic [29:0] poly_advance(input logic [29:0] prev);
      logic [4:0]  top;
      logic [29:0] c;
      top = prev[29:25];
      c   = {prev[24:0], 5'd0};
      if (top[0]) c = c ^ 30'h3b6a57b2;
      if (top[1]) c = c ^ 30'h26508e6d;
      if (top[2]) c = c ^ 30'h1ea119fa;
      if (top[3]) c = c ^ 30'h3d4233dd;
      if (top[4]) c = c ^ 30'h2a1462b3;
      return c;
   endfunction

   // polymod over the expanded "bc" prefix
   function automatic logic [29:0] hrp_checksum();
      logic [29:0] c;
      c = 30'd1;
      c = poly_advance(c) ^ 30'(CH_B[7:5]);
      c = poly_advance(c) ^ 30'(CH_C[7:5]);
      c = poly_advance(c);
      c = poly_advance(c) ^ 30'(CH_B[4:0]);
      c = poly_advance(c) ^ 30'(CH_C[4:0]);
      return c;
   endfunction

   localparam logic [29:0] HRP_CHECK = hrp_checksum();

   // {found, value} for the bech32 charset
   function automatic logic [5:0] charset_lookup(input logic [7:0] ch);
      logic [5:0] r;
      case (ch)
         8'h71:   r = {1'b1, 5'd0};   // q
         8'h70:   r = {1'b1, 5'd1};   // p
         8'h7a:   r = {1'b1, 5'd2};   // z
         8'h72:   r = {1'b1, 5'd3};   // r
         8'h79:   r = {1'b1, 5'd4};   // y
         8'h39:   r = {1'b1, 5'd5};   // 9
         8'h78:   r = {1'b1, 5'd6};   // x
         8'h38:   r = {1'b1, 5'd7};   // 8
         8'h67:   r = {1'b1, 5'd8};   // g
         8'h66:   r = {1'b1, 5'd9};   // f
         8'h32:   r = {1'b1, 5'd10};  // 2
         8'h74:   r = {1'b1, 5'd11};  // t
         8'h76:   r = {1'b1, 5'd12};  // v
         8'h64:   r = {1'b1, 5'd13};  // d
         8'h77:   r = {1'b1, 5'd14};  // w
         8'h30:   r = {1'b1, 5'd15};  // 0
         8'h73:   r = {1'b1, 5'd16};  // s
         8'h33:   r = {1'b1, 5'd17};  // 3
         8'h6a:   r = {1'b1, 5'd18};  // j
         8'h6e:   r = {1'b1, 5'd19};  // n
         8'h35:   r = {1'b1, 5'd20};  // 5
         8'h34:   r = {1'b1, 5'd21};  // 4
         8'h6b:   r = {1'b1, 5'd22};  // k
         8'h68:   r = {1'b1, 5'd23};  // h
         8'h63:   r = {1'b1, 5'd24};  // c
         8'h65:   r = {1'b1, 5'd25};  // e
         8'h36:   r = {1'b1, 5'd26};  // 6
         8'h6d:   r = {1'b1, 5'd27};  // m
         8'h75:   r = {1'b1, 5'd28};  // u
         8'h61:   r = {1'b1, 5'd29};  // a
         8'h37:   r = {1'b1, 5'd30};  // 7
         8'h6c:   r = {1'b1, 5'd31};  // l
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/bech32chk_front.sv */
// front stage: accepts a request and registers its character classification
module bech32chk_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_ch,
   input  logic                    req_last,
   output logic                    item_valid,
   output bech32chk_pkg::class_type item,
   input  logic                    queue_full
);
   import bech32chk_pkg::*;

   logic      valid_ff, valid_in;
   class_type item_ff, item_in;
   logic      accept;
   logic [5:0] look;

   assign req_full = valid_ff && queue_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      look             = charset_lookup(req_ch);
      item_in.bad_char = (req_ch < 8'd33) || (req_ch > 8'd126) ||
                         ((req_ch >= 8'h41) && (req_ch <= 8'h5a));
      item_in.is_b     = (req_ch == CH_B);
      item_in.is_c     = (req_ch == CH_C);
      item_in.is_one   = (req_ch == CH_ONE);
      item_in.in_set   = look[5];
      item_in.value    = look[4:0];
      item_in.last     = req_last;
      if (accept) begin
         valid_in = 1'b1;
      end else if (!queue_full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/bech32chk_queue.sv */
// short queue of classified characters between front and back
module bech32chk_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bech32chk_pkg::class_type push_item,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output bech32chk_pkg::class_type head_item
);
   import bech32chk_pkg::*;

   class_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/bech32chk_back.sv */
// back stage: position checks, polymod, regrouping and the verdict register
module bech32chk_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  bech32chk_pkg::class_type head_item,
   output logic                    head_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_valid_res
);
   import bech32chk_pkg::*;

   logic [6:0]  pos_ff, pos_in;
   logic        failed_ff, failed_in;
   logic [29:0] poly_ff, poly_in;
   logic [4:0]  delay_ff [DELAY_DEPTH];
   logic [4:0]  delay_in [DELAY_DEPTH];
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  bits_ff, bits_in;
   logic [3:0]  rcount_ff, rcount_in;
   logic [5:0]  bytes_ff, bytes_in;
   logic        version_ff, version_in;
   logic        out_valid_ff, out_valid_in;
   logic        out_ff, out_in;
   logic        take;
   logic        ok;
   logic [7:0]  pad_mask;

   assign take     = head_valid && (!head_item.last || !out_valid_ff || rsp_pop);
   assign head_pop = take;

   always_comb begin
      pos_in     = pos_ff;
      failed_in  = failed_ff;
      poly_in    = poly_ff;
      delay_in   = delay_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      rcount_in  = rcount_ff;
      bytes_in   = bytes_ff;
      version_in = version_ff;
      ok         = 1'b0;
      pad_mask   = 8'd0;

      if (head_item.bad_char || (pos_ff >= 7'(MAX_CHARS))) begin
         failed_in = 1'b1;
      end
      if (!failed_in) begin
         if (pos_ff == 7'd0) begin
            failed_in = !head_item.is_b;
         end else if (pos_ff == 7'd1) begin
            failed_in = !head_item.is_c;
         end else if (pos_ff == 7'd2) begin
            if (!head_item.is_one) begin
               failed_in = 1'b1;
            end else begin
               poly_in = HRP_CHECK;
            end
         end else if (!head_item.in_set) begin
            failed_in = 1'b1;
         end else begin
            poly_in = poly_advance(poly_ff) ^ 30'(head_item.value);
            if (pos_ff == 7'd3) begin
               if (head_item.value != 5'd0) begin
                  failed_in = 1'b1;
               end else begin
                  version_in = 1'b1;
               end
            end else if (fill_ff >= 3'(DELAY_DEPTH)) begin
               // oldest delayed value goes to the 5-to-8 bit regroup
               bits_in   = {bits_ff[2:0], delay_ff[0]};
               rcount_in = rcount_ff + 4'd5;
               if (rcount_in >= 4'd8) begin
                  rcount_in = rcount_in - 4'd8;
                  if (bytes_ff < 6'(BYTES_SAT)) begin
                     bytes_in = bytes_ff + 6'd1;
                  end
               end
               for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
                  delay_in[i] = delay_ff[i+1];
               end
               delay_in[DELAY_DEPTH-1] = head_item.value;
            end else begin
               delay_in[fill_ff] = head_item.value;
               fill_in           = fill_ff + 3'd1;
            end
         end
      end

      if (pos_ff < 7'(POS_SAT)) begin
         pos_in = pos_ff + 7'd1;
      end

      if (head_item.last) begin
         pad_mask = (8'd1 << rcount_in[2:0]) - 8'd1;
         ok = !failed_in
            && (pos_in >= 7'(MIN_CHARS)) && (pos_in <= 7'(MAX_CHARS))
            && (poly_in == 30'd1)
            && version_in
            && (fill_in == 3'(DELAY_DEPTH))
            && (rcount_in < 4'd5)
            && ((bits_in & pad_mask) == 8'd0)
            && (bytes_in == 6'(PROGRAM_BYTES));
         pos_in     = '0;
         failed_in  = 1'b0;
         poly_in    = 30'd1;
         fill_in    = '0;
         bits_in    = '0;
         rcount_in  = '0;
         bytes_in   = '0;
         version_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take && head_item.last) begin
         out_valid_in = 1'b1;
         out_in       = ok;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         failed_ff    <= 1'b0;
         poly_ff      <= 30'd1;
         fill_ff      <= '0;
         bits_ff      <= '0;
         rcount_ff    <= '0;
         bytes_ff     <= '0;
         version_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            pos_ff     <= pos_in;
            failed_ff  <= failed_in;
            poly_ff    <= poly_in;
            fill_ff    <= fill_in;
            bits_ff    <= bits_in;
            rcount_ff  <= rcount_in;
            bytes_ff   <= bytes_in;
            version_ff <= version_in;
         end
      end
      if (take) begin
         delay_ff <= delay_in;
      end
      out_ff <= out_in;
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_valid_res = out_ff;

endmodule

/* rtl/bech32_segwit_v0_address_checker.sv */
// bech32 segwit v0 address checker: one character per request, one verdict per address
// throughput: one character per cycle while req_full stays low, set by the polymod step in the back stage
// the verdict passes from the edge that accepts the final character through the front register,
//   then the queue, then the verdict register, to reach the result ports
// reset: synchronous, active high; clears all counters, the queue and the verdict valid flag
module bech32_segwit_v0_address_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_valid_res
);
   import bech32chk_pkg::*;

   logic      front_valid;
   class_type front_item;
   logic      queue_full;
   logic      head_valid;
   class_type head_item;
   logic      head_pop;

   bech32chk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .item_valid (front_valid),
      .item       (front_item),
      .queue_full (queue_full)
   );

   bech32chk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   bech32chk_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule

/* tb/address_verdict_checker.sv */
// watches both channels, predicts each address verdict and compares it with the block's result
module address_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_valid_res,
   output int unsigned mismatch_count,
   output int unsigned verdicts_due
);
   import bech32chk_pkg::*;

   localparam logic [0:31][7:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [4:0][29:0] BCH_GEN  =
      {30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2};

   logic        expected_verdicts[$];
   int unsigned errors = 0;

   logic [6:0]  pos_cnt;
   logic        sticky_err;
   logic [29:0] poly;
   logic [4:0]  held[DELAY_DEPTH];
   logic [2:0]  held_n;
   logic [7:0]  acc_bits;
   logic [3:0]  acc_n;
   logic [5:0]  prog_bytes;
   logic        ver_ok;

   function automatic logic [29:0] bch_step(input logic [29:0] acc, input logic [4:0] v);
      logic [29:0] nxt;
      nxt = {acc[24:0], v};
      for (int k = 0; k < 5; k++)
         if (acc[25 + k]) nxt = nxt ^ BCH_GEN[k];
      return nxt;
   endfunction

   task automatic clear_address();
      pos_cnt    = '0;
      sticky_err = 1'b0;
      poly       = 30'd1;
      held_n     = '0;
      acc_bits   = '0;
      acc_n      = '0;
      prog_bytes = '0;
      ver_ok     = 1'b0;
   endtask

   always @(posedge clock) begin
      logic [7:0] c;
      int         v;
      logic       ok;
      logic       want;
      if (reset) begin
         clear_address();
         expected_verdicts.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               $error("valid_res: no verdict expected, actual %0b", rsp_valid_res);
               errors++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_valid_res !== want) begin
                  $error("valid_res: expected %0b, actual %0b", want, rsp_valid_res);
                  errors++;
               end
            end
         end
         if (req_push && !req_full) begin
            c = req_ch;
            if (c < 8'd33 || c > 8'd126 || (c >= "A" && c <= "Z")) sticky_err = 1'b1;
            if (int'(pos_cnt) + 1 > MAX_CHARS) sticky_err = 1'b1;
            if (!sticky_err) begin
               case (pos_cnt)
                  7'd0: if (c != CH_B) sticky_err = 1'b1;
                  7'd1: if (c != CH_C) sticky_err = 1'b1;
                  7'd2: begin
                     if (c != CH_ONE) sticky_err = 1'b1;
                     else poly = bch_step(bch_step(bch_step(bch_step(bch_step(30'd1,
                        5'(CH_B >> 5)), 5'(CH_C >> 5)), 5'd0), 5'(CH_B)), 5'(CH_C));
                  end
                  default: begin
                     v = -1;
                     for (int k = 0; k < 32; k++)
                        if (ALPHABET[k] == c) v = k;
                     if (v < 0) begin
                        sticky_err = 1'b1;
                     end else begin
                        poly = bch_step(poly, 5'(v));
                        if (pos_cnt == 7'd3) begin
                           if (v != 0) sticky_err = 1'b1;
                           else ver_ok = 1'b1;
                        end else if (held_n >= DELAY_DEPTH) begin
                           // oldest held value goes into the 5-to-8 bit regroup
                           acc_bits = {acc_bits[2:0], held[0]};
                           acc_n    = acc_n + 4'd5;
                           if (acc_n >= 4'd8) begin
                              acc_n = acc_n - 4'd8;
                              if (prog_bytes < BYTES_SAT) prog_bytes++;
                           end
                           for (int k = 0; k < DELAY_DEPTH - 1; k++) held[k] = held[k + 1];
                           held[DELAY_DEPTH - 1] = 5'(v);
                        end else begin
                           held[held_n] = 5'(v);
                           held_n++;
                        end
                     end
                  end
               endcase
            end
            if (pos_cnt < POS_SAT) pos_cnt++;
            if (req_last) begin
               ok = !sticky_err && pos_cnt >= MIN_CHARS && pos_cnt <= MAX_CHARS
                  && poly == 30'd1 && ver_ok && held_n == DELAY_DEPTH && acc_n < 4'd5
                  && (acc_bits & ((8'd1 << acc_n) - 8'd1)) == 8'd0
                  && prog_bytes == PROGRAM_BYTES;
               expected_verdicts.push_back(ok);
               clear_address();
            end
         end
      end
      verdicts_due   <= expected_verdicts.size();
      mismatch_count <= errors;
   end

endmodule

/* tb/testbench.sv */
// top of the address checker testbench: clock, reset, address stimulus and the final verdict
module testbench;
   import bech32chk_pkg::*;

   localparam logic [0:31][7:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [4:0][29:0] BCH_GEN  =
      {30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2};
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_OFF       = 1500;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic [7:0] req_ch    = 8'd0;
   logic       req_last  = 1'b0;
   logic       rsp_pop   = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic       rsp_valid_res;

   int unsigned mismatch_total;
   int unsigned verdicts_due;

   logic [4:0] vals[$];
   logic [7:0] text[$];
   int         sent_chars  = 0;
   int         sent_addrs  = 0;
   int         stall_count = 0;
   bit         steady;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bech32_segwit_v0_address_checker dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_valid_res (rsp_valid_res)
   );

   address_verdict_checker verdict_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_valid_res  (rsp_valid_res),
      .mismatch_count (mismatch_total),
      .verdicts_due   (verdicts_due)
   );

   function automatic logic [29:0] gen_step(input logic [29:0] acc, input logic [4:0] v);
      logic [29:0] nxt;
      nxt = {acc[24:0], v};
      for (int k = 0; k < 5; k++)
         if (acc[25 + k]) nxt = nxt ^ BCH_GEN[k];
      return nxt;
   endfunction

   function automatic int pick_pos(input int lo);
      return $urandom_range(lo, text.size() - 1);
   endfunction

   // version value followed by program bytes regrouped to 5 bits with zero padding
   task automatic program_values(input int nbytes, input logic [4:0] version, input int fill);
      logic [15:0] acc;
      int          nbits;
      vals.delete();
      vals.push_back(version);
      acc   = '0;
      nbits = 0;
      repeat (nbytes) begin
         acc   = {acc[7:0], (fill < 0) ? 8'($urandom) : 8'(fill)};
         nbits = nbits + 8;
         while (nbits >= 5) begin
            nbits = nbits - 5;
            vals.push_back(5'(acc >> nbits));
         end
      end
      if (nbits > 0) vals.push_back(5'(acc << (5 - nbits)));
   endtask

   task automatic raw_values(input int n);
      vals.delete();
      vals.push_back(5'd0);
      repeat (n - 1) vals.push_back(5'($urandom));
   endtask

   // prefix, data characters and a correct checksum
   task automatic seal();
      logic [29:0] c;
      c = gen_step(gen_step(gen_step(gen_step(gen_step(30'd1,
         5'(CH_B >> 5)), 5'(CH_C >> 5)), 5'd0), 5'(CH_B)), 5'(CH_C));
      text.delete();
      text.push_back(CH_B);
      text.push_back(CH_C);
      text.push_back(CH_ONE);
      foreach (vals[i]) begin
         c = gen_step(c, vals[i]);
         text.push_back(ALPHABET[vals[i]]);
      end
      repeat (6) c = gen_step(c, 5'd0);
      c = c ^ 30'd1;
      for (int k = 0; k < 6; k++) text.push_back(ALPHABET[5'(c >> (5 * (5 - k)))]);
   endtask

   task automatic offer(input logic [7:0] ch, input logic fin);
      int gap;
      bit held_off;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= ch;
      req_last <= fin;
      // full is sampled ahead of the edge that would take the request
      do begin
         @(negedge clock);
         held_off = req_full;
         @(posedge clock);
      end while (held_off);
      sent_chars++;
   endtask

   task automatic send_text();
      steady = ($urandom_range(0, 3) == 0);
      foreach (text[i]) offer(text[i], i == text.size() - 1);
      sent_addrs++;
   endtask

   initial begin
      int p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      program_values(20, 5'd0, 8'h00); seal(); send_text();
      program_values(20, 5'd0, 8'hff); seal(); send_text();
      program_values(20, 5'd0, -1); seal(); send_text();
      program_values(20, 5'd0, -1); seal(); text[5] = "Q"; send_text();
      program_values(20, 5'd31, -1); seal(); send_text();
      program_values(32, 5'd0, -1); seal(); send_text();
      raw_values(33); seal(); send_text();
      raw_values(31); seal(); send_text();
      program_values(20, 5'd0, -1); seal(); text[10] = CH_ONE; send_text();
      program_values(20, 5'd0, -1); seal(); text[0] = "t"; send_text();
      raw_values(4); seal(); send_text();
      raw_values(5); seal(); send_text();
      raw_values(81); seal(); send_text();
      raw_values(131); seal(); send_text();
      program_values(20, 5'd0, -1); seal();
      text[20] = (text[20] == "q") ? "p" : "q";
      send_text();
      text = {8'h00, 8'hff, 8'h20, 8'h21, 8'h7e, 8'h7f}; send_text();
      text = {CH_B}; send_text();

      while (sent_chars < 1350 || sent_addrs < 36) begin
         case ($urandom_range(0, 19))
            11: begin program_values($urandom_range(0, 40), 5'd0, -1); seal(); end
            12: begin raw_values($urandom_range(1, 60)); seal(); end
            13: begin
               program_values(20, 5'd0, -1); seal();
               text[pick_pos(3)] = ALPHABET[$urandom_range(0, 31)];
            end
            14: begin
               program_values(20, 5'd0, -1); seal();
               text[pick_pos(0)] = 8'($urandom);
            end
            15: begin program_values(20, 5'($urandom_range(1, 31)), -1); seal(); end
            16: begin
               text.delete();
               repeat ($urandom_range(1, 40)) text.push_back(8'($urandom));
            end
            17: begin
               program_values(20, 5'd0, -1); seal();
               p = pick_pos(3);
               if (text[p] >= "a" && text[p] <= "z") text[p] = text[p] - 8'd32;
               else text[p] = 8'("A" + $urandom_range(0, 25));
            end
            18: begin
               program_values(20, 5'd0, -1); seal();
               text[pick_pos(3)] = CH_ONE;
            end
            19: begin raw_values($urandom_range(76, 125)); seal(); end
            default: begin program_values(20, 5'd0, -1); seal(); end
         endcase
         send_text();
      end

      req_push <= 1'b0;
      do @(posedge clock); while (verdicts_due != 0);
      repeat (12) @(posedge clock);
      if (mismatch_total == 0 && verdicts_due == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side: random pop delays, quiet runs, and one long hold-off to fill the block
   initial begin
      int wait_n;
      int quiet;
      int verdicts_taken;
      bit idle;
      quiet          = 0;
      verdicts_taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (verdicts_taken == 20) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end
         if (quiet > 0) begin
            wait_n = 0;
            quiet--;
         end else begin
            wait_n = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) quiet = $urandom_range(4, 12);
         end
         if (wait_n > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do begin
            @(negedge clock);
            idle = rsp_empty;
            @(posedge clock);
         end while (idle);
         verdicts_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_count <= 0;
      end else if (stall_count == WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

endmodule
